// File: src/ddf_pkg.sv
// ---------------------------------------------------------------------------
// ddf_pkg
// shared constants, cell control word and segment lookup for the formatter
// ---------------------------------------------------------------------------
package ddf_pkg;

    // binary input width and number of bcd cells it needs
    localparam int VALUE_W     = 32;
    localparam int BCD_DIGITS  = 10;

    // display positions and the most slides the window can take
    localparam int DIGIT_COUNT = 4;
    localparam int SLIDE_MAX   = BCD_DIGITS - DIGIT_COUNT;

    localparam int CNT_W       = $clog2(VALUE_W);

    localparam logic [3:0] BLANK_CODE = 4'd10;

    // control word broadcast to every bcd cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 adjust then shift one bit in
        logic slide;   // take the lower neighbor's digit
    } t_cell_ctl;

    // segment pattern, bits 0..6 = pins 8,9,11,12,13,14,15; blank drives nothing
    function automatic logic [6:0] seg_of(input logic [3:0] code);
        logic [6:0] seg;
        unique case (code)
            4'd0:    seg = 7'h77;
            4'd1:    seg = 7'h05;
            4'd2:    seg = 7'h3B;
            4'd3:    seg = 7'h2F;
            4'd4:    seg = 7'h4D;
            4'd5:    seg = 7'h6E;
            4'd6:    seg = 7'h7E;
            4'd7:    seg = 7'h25;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: src/ddf_bcd_cell.sv
// ---------------------------------------------------------------------------
// ddf_bcd_cell
// one decimal digit of the double-dabble chain, also slides toward the msd
// ---------------------------------------------------------------------------
module ddf_bcd_cell
    import ddf_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_bit,       // carry from the lower cell or the binary msb
    input  logic [3:0] i_digit_lo,  // lower neighbor digit for sliding
    output logic [3:0] o_digit,
    output logic       o_carry
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add 3 when the digit would overflow a decimal place after doubling
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        priority if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctl.slide) begin
            n_digit = i_digit_lo;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// File: src/decimal_display_formatter.sv
// ---------------------------------------------------------------------------
// decimal_display_formatter
// 32-bit binary to four seven-segment positions, leading digits kept
// ---------------------------------------------------------------------------
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ----------------------------
//  input     i_value                             start high while busy low
//  result    o_digit_code_0..3, o_segments_0..3  o_valid high for one cycle
//
//  sequence: 32 double-dabble steps through the row of ten bcd cells, then
//  0 to 6 slide steps until the top cell holds a nonzero digit, then the
//  result word is registered and o_valid is raised
//  reset: i_rst_n low returns the sequencer to idle and drops o_valid
//  stalls: the receiver takes every word; busy stays high from accept until
//  the result word is shown, and a new word can be started in that cycle
//
module decimal_display_formatter
    import ddf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    output logic [3:0]         o_digit_code_0,
    output logic [3:0]         o_digit_code_1,
    output logic [3:0]         o_digit_code_2,
    output logic [3:0]         o_digit_code_3,
    output logic [6:0]         o_segments_0,
    output logic [6:0]         o_segments_1,
    output logic [6:0]         o_segments_2,
    output logic [6:0]         o_segments_3
);

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [VALUE_W-1:0] r_bin;
    logic [VALUE_W-1:0] n_bin;
    logic               r_valid;
    logic               n_valid;

    logic               w_accept;
    logic               w_align_done;
    t_cell_ctl          w_ctl;

    // cell outputs, index 0 is the least significant decimal digit
    logic [3:0]         w_digit [BCD_DIGITS];
    logic               w_carry [BCD_DIGITS];

    // display window, index 0 is the leftmost position
    logic [3:0]         w_win   [DIGIT_COUNT];
    logic [3:0]         w_code  [DIGIT_COUNT];
    logic [3:0]         r_code  [DIGIT_COUNT];
    logic [6:0]         r_seg   [DIGIT_COUNT];

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;

    // window is done sliding once the top cell is nonzero or all slack is used
    assign w_align_done = (w_digit[BCD_DIGITS-1] != 4'd0) || (r_cnt == CNT_W'(SLIDE_MAX));

    always_comb begin
        w_ctl.clear  = w_accept;
        w_ctl.dabble = (r_state == ST_CONV);
        w_ctl.slide  = (r_state == ST_ALIGN) && !w_align_done;
    end

    // row of bcd cells, carries ripple upward, slides move digits upward
    genvar g;
    generate
        for (g = 0; g < BCD_DIGITS; g++) begin : g_cell
            logic       w_bit_in;
            logic [3:0] w_lo_in;
            if (g == 0) begin : g_first
                assign w_bit_in = r_bin[VALUE_W-1];
                assign w_lo_in  = 4'd0;
            end else begin : g_rest
                assign w_bit_in = w_carry[g-1];
                assign w_lo_in  = w_digit[g-1];
            end
            ddf_bcd_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_bit      (w_bit_in),
                .i_digit_lo (w_lo_in),
                .o_digit    (w_digit[g]),
                .o_carry    (w_carry[g])
            );
        end
    endgenerate

    // top cells form the window, leftmost first
    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            w_win[i] = w_digit[BCD_DIGITS-1-i];
        end
    end

    // blank leading zeros, the rightmost position always shows a digit
    always_comb begin
        logic lead;
        lead = 1'b1;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            lead = lead && (w_win[i] == 4'd0) && (i < DIGIT_COUNT - 1);
            w_code[i] = lead ? BLANK_CODE : w_win[i];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CONV;
                    n_cnt   = '0;
                    n_bin   = i_value;
                end
            end
            ST_CONV: begin
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_state = ST_ALIGN;
                    n_cnt   = '0;
                end
            end
            ST_ALIGN: begin
                if (w_align_done) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_bin <= n_bin;
    end

    // result word register, loaded as the window settles
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_code[i] <= w_code[i];
                r_seg[i]  <= seg_of(w_code[i]);
            end
        end
    end

    assign o_digit_code_0 = r_code[0];
    assign o_digit_code_1 = r_code[1];
    assign o_digit_code_2 = r_code[2];
    assign o_digit_code_3 = r_code[3];
    assign o_segments_0   = r_seg[0];
    assign o_segments_1   = r_seg[1];
    assign o_segments_2   = r_seg[2];
    assign o_segments_3   = r_seg[3];

`ifndef SYNTHESIS
    // a word is always followed by a long conversion, never back to back
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // an accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // results appear only as the sequencer returns to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == ST_ALIGN))
        else $error("result word outside the align exit");

    // the rightmost position is never blank
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_code_3 <= 4'd9))
        else $error("rightmost position not a digit");

    // blanking only runs from the left
    a_blank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_digit_code_1 == BLANK_CODE)) |-> (o_digit_code_0 == BLANK_CODE))
        else $error("blank position right of a digit");
`endif

endmodule

// File: tb/sv/decimal_display_formatter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_display_formatter_tb
// self-checking bench for the four-position decimal display formatter
// ---------------------------------------------------------------------------
// values go in through the start/busy command port in bursts with random
// gaps. Each accepted value is turned into its expected display word by a
// local formatter: leading four digits kept, leading zeros blanked, segment
// patterns looked up. Every o_valid word is compared field by field with the
// oldest expected word.
// ---------------------------------------------------------------------------
module decimal_display_formatter_tb
    import ddf_pkg::*;
();

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned RANDOM_ITEMS = 400;
    // worst case is about 425 words, each with its conversion and a sender
    // gap, so this leaves a wide margin
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // cycles to keep watching for stray words once nothing is pending
    localparam int unsigned TAIL_CYCLES  = 45;

    // segment patterns for digits 9 down to 0, indexed by digit
    localparam logic [9:0][6:0] DIGIT_SEGMENTS = {
        7'h6F, 7'h7F, 7'h25, 7'h7E, 7'h6E, 7'h4D, 7'h2F, 7'h3B, 7'h05, 7'h77
    };

    // one display word, position 0 is the leftmost
    typedef struct packed {
        logic [DIGIT_COUNT-1:0][3:0] code;
        logic [DIGIT_COUNT-1:0][6:0] seg;
    } t_display_word;

    // -----------------------------------------------------------------------
    // scoreboard: formats accepted values, holds them in order, checks words
    // -----------------------------------------------------------------------
    class display_scoreboard;
        t_display_word pending_words[$];
        int unsigned   mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // leading digits of the value, blanked and mapped to segments
        function t_display_word format_value(logic [VALUE_W-1:0] value);
            t_display_word      word;
            logic [VALUE_W-1:0] scan;
            logic [VALUE_W-1:0] rest;
            int unsigned        digits;
            bit                 leading;
            scan   = value;
            digits = 1;
            while (scan >= 10) begin
                scan = scan / 10;
                digits++;
            end
            // drop the low digits that do not fit
            rest = value;
            while (digits > DIGIT_COUNT) begin
                rest = rest / 10;
                digits--;
            end
            for (int pos = DIGIT_COUNT - 1; pos >= 0; pos--) begin
                word.code[pos] = 4'(rest % 10);
                rest = rest / 10;
            end
            // blank zeros left of the first nonzero digit, never the last one
            leading = 1'b1;
            for (int pos = 0; pos < DIGIT_COUNT; pos++) begin
                if (leading && pos < DIGIT_COUNT - 1 && word.code[pos] == 4'd0) begin
                    word.code[pos] = BLANK_CODE;
                end else begin
                    leading = 1'b0;
                end
                word.seg[pos] = (word.code[pos] == BLANK_CODE) ? 7'h00
                              : DIGIT_SEGMENTS[word.code[pos]];
            end
            return word;
        endfunction

        function void note_value(logic [VALUE_W-1:0] value);
            pending_words.push_back(format_value(value));
        endfunction

        function int unsigned pending_count();
            return pending_words.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task check_word(t_display_word seen);
            t_display_word want;
            if (pending_words.size() == 0) begin
                report_mismatch("result word with no value pending");
            end else begin
                want = pending_words.pop_front();
                for (int pos = 0; pos < DIGIT_COUNT; pos++) begin
                    if (seen.code[pos] !== want.code[pos])
                        report_mismatch($sformatf("digit_code_%0d got %0d want %0d",
                                        pos, seen.code[pos], want.code[pos]));
                    if (seen.seg[pos] !== want.seg[pos])
                        report_mismatch($sformatf("segments_%0d got %02h want %02h",
                                        pos, seen.seg[pos], want.seg[pos]));
                end
            end
        endtask
    endclass

    // -----------------------------------------------------------------------
    // block ports, every input known from time zero
    // -----------------------------------------------------------------------
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               busy;
    logic               o_valid;
    logic [3:0]         o_digit_code_0, o_digit_code_1, o_digit_code_2, o_digit_code_3;
    logic [6:0]         o_segments_0, o_segments_1, o_segments_2, o_segments_3;

    display_scoreboard  sb;
    t_display_word      seen_word;
    int unsigned        cycle_count = 0;

    decimal_display_formatter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_digit_code_0 (o_digit_code_0),
        .o_digit_code_1 (o_digit_code_1),
        .o_digit_code_2 (o_digit_code_2),
        .o_digit_code_3 (o_digit_code_3),
        .o_segments_0   (o_segments_0),
        .o_segments_1   (o_segments_1),
        .o_segments_2   (o_segments_2),
        .o_segments_3   (o_segments_3)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // watchdog: a hung handshake or a lost word ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL decimal_display_formatter");
            $finish;
        end
    end

    // result monitor: outputs are read at the edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_word.code[0] = o_digit_code_0;
            seen_word.code[1] = o_digit_code_1;
            seen_word.code[2] = o_digit_code_2;
            seen_word.code[3] = o_digit_code_3;
            seen_word.seg[0]  = o_segments_0;
            seen_word.seg[1]  = o_segments_1;
            seen_word.seg[2]  = o_segments_2;
            seen_word.seg[3]  = o_segments_3;
            sb.check_word(seen_word);
        end
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------

    // present one word and hold it until an edge sees start high, busy low;
    // start is left high so a following word goes out back to back
    task send_value(logic [VALUE_W-1:0] value);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        sb.note_value(value);
    endtask

    // sender gap with junk on the value bus, it must not be picked up
    task idle_cycles(int unsigned count);
        if (count != 0) begin
            start <= 1'b0;
            repeat (count) begin
                i_value <= $urandom;
                @(posedge i_clk);
            end
        end
    endtask

    // hold off until every pending word has come back
    task drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    // random value, mostly spread by digit count so every width shows up
    function logic [VALUE_W-1:0] random_value();
        longint unsigned lo, hi, acc;
        int unsigned     ndig;
        logic [VALUE_W-1:0] value;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // uniform within a random decimal width
                ndig = $urandom_range(1, 10);
                lo   = (ndig == 1) ? 0 : 1;
                hi   = 1;
                for (int k = 0; k < ndig; k++) hi = hi * 10;
                for (int k = 1; k < ndig; k++) lo = lo * 10;
                hi = hi - 1;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                value = VALUE_W'(lo + ($urandom % (hi - lo + 1)));
            end
            5, 6: begin
                // digits built one by one, zeros likely inside the number
                ndig = $urandom_range(1, 10);
                acc  = 0;
                for (int k = 0; k < ndig; k++)
                    acc = acc * 10 + (($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 9));
                if (acc > 64'hFFFF_FFFF) acc = acc / 10;
                value = VALUE_W'(acc);
            end
            7:       value = $urandom;
            8:       value = 32'hFFFF_FFFF - $urandom_range(0, 300);
            default: value = $urandom_range(0, 120);
        endcase
        return value;
    endfunction

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    logic [VALUE_W-1:0] directed_values[$] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd305, 32'd999,
        32'd1000, 32'd1001, 32'd2005, 32'd4567, 32'd9999, 32'd10000,
        32'd10009, 32'd99999, 32'd100000, 32'd1234567, 32'd1000000000,
        32'd1234567890, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    initial begin
        int unsigned sent;
        int unsigned burst;
        bit          drained_midway;
        sb = new();
        drained_midway = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: extremes, zero, blanking and truncation corners;
        // first half back to back, second half with short gaps
        foreach (directed_values[k]) begin
            send_value(directed_values[k]);
            if (k >= directed_values.size() / 2)
                idle_cycles($urandom_range(0, 40));
        end
        drain_results();

        // random part: bursts of back to back words, gaps of any length so
        // the next start lands on every phase of the conversion
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_value(random_value());
                sent++;
            end
            if (!drained_midway && sent >= RANDOM_ITEMS / 2) begin
                drained_midway = 1'b1;
                drain_results();
            end else if ($urandom_range(0, 4) == 0) begin
                idle_cycles($urandom_range(40, 120));
            end else begin
                idle_cycles($urandom_range(0, 45));
            end
        end

        // wind down: everything back, then watch for stray words
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_count() != 0)
            sb.report_mismatch("expected words left over at the end");

        if (sb.mismatch_count == 0) begin
            $display("PASS decimal_display_formatter");
        end else begin
            $display("FAIL decimal_display_formatter");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/ddf_pkg.sv
src/ddf_bcd_cell.sv
src/decimal_display_formatter.sv
tb/sv/decimal_display_formatter_tb.sv
